// ===== hw/rtl/lbbc_pkg.sv =====
package lbbc_pkg;

  localparam int unsigned ACTION_W = 2;
  localparam int unsigned LABEL_W  = 6;
  localparam int unsigned COORD_W  = 12;
  localparam int unsigned FW_W     = 13;
  localparam int unsigned CENTER_W = 24;

  localparam logic [FW_W-1:0] FW_RESET = 13'd640;

  localparam logic [ACTION_W-1:0] ACT_PIXEL  = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_MERGE  = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_FINISH = 2'd2;

  typedef enum logic [2:0] {
    ST_RUN,
    ST_READ,
    ST_MID,
    ST_MUL,
    ST_EMIT
  } lbbc_state_e;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [LABEL_W-1:0]  label;
    logic [COORD_W-1:0]  x_low;
    logic [COORD_W-1:0]  y_low;
    logic [COORD_W-1:0]  x_high;
    logic [COORD_W-1:0]  y_high;
  } lbbc_in_t;

  typedef struct packed {
    logic [LABEL_W-1:0]  out_label;
    logic [CENTER_W-1:0] center_index;
    logic                last;
  } lbbc_out_t;

  typedef logic [FW_W-1:0] lbbc_cfg_t;

  typedef struct packed {
    logic [COORD_W-1:0] min_x;
    logic [COORD_W-1:0] min_y;
    logic [COORD_W-1:0] max_x;
    logic [COORD_W-1:0] max_y;
  } lbbc_box_t;

  // lo + (hi - lo) / 2, division truncating toward zero
  function automatic logic [COORD_W-1:0] mid_point(logic [COORD_W-1:0] lo,
                                                   logic [COORD_W-1:0] hi);
    logic signed [COORD_W:0] diff;
    logic signed [COORD_W:0] half;
    diff = $signed({1'b0, hi}) - $signed({1'b0, lo});
    half = (diff + $signed({{COORD_W{1'b0}}, diff[COORD_W]})) >>> 1;
    return lo + half[COORD_W-1:0];
  endfunction

endpackage

// ===== hw/rtl/lbbc_chan_if.sv =====
interface lbbc_chan_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== hw/rtl/label_bounding_box_centers.sv =====
// Per-label bounding-box table with center readout.
// Channels: in_i (sink) takes requests of action/label/coordinates; out_o
// (source) delivers out_label, center_index and last; cfg_i (sink, always
// ready) writes frame_width.
// Pixel and merge requests: one per cycle outside a finish scan. Each reads
// the label's box from a registered memory read on acceptance and writes the
// folded box back on the next cycle; a request to the label written just
// before takes the new box from a forwarding register. The table is current
// once the folded box has been written back.
// Finish: in_i stalls while the table is scanned through the single memory read
// port; absent labels below the highest present one are stepped over, and each
// present label passes through read, midpoint, multiply and emit steps. The
// last result carries last = 1 and the table is left empty. An empty table
// gives no result.
// Results sit in an output register; a stalled receiver holds the scan at
// its emit step, nothing is dropped.
// Reset: present bits cleared, frame_width = 640. Box memory is not
// cleared; entries are only used behind a set present bit.
module label_bounding_box_centers #(
  parameter int unsigned NUM_LABELS = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  lbbc_chan_if.sink   in_i,
  lbbc_chan_if.source out_o,
  lbbc_chan_if.sink   cfg_i
);
  import lbbc_pkg::*;

  localparam int unsigned AW = $clog2(NUM_LABELS);

  lbbc_state_e state_q, state_d;

  logic [FW_W-1:0]       fw_q;
  logic [NUM_LABELS-1:0] present_q;
  logic [AW-1:0]         idx_q, idx_d;

  logic                  s1_valid_q;
  logic [AW-1:0]         s1_lbl_q;
  lbbc_box_t             s1_box_q;

  logic                  fwd_valid_q;
  logic [AW-1:0]         fwd_lbl_q;
  lbbc_box_t             fwd_box_q;

  lbbc_box_t             box_mem [NUM_LABELS];
  lbbc_box_t             rd_box_q;
  logic                  rd_en;
  logic [AW-1:0]         rd_addr;

  logic [COORD_W-1:0]    cx_q, cy_q;
  logic [CENTER_W-1:0]   center_q;
  logic                  out_valid_q;
  lbbc_out_t             out_q;

  logic                  accept, take_px, fin_acc, lbl_ok;
  logic                  in_ready, scan_rd, emit, out_free, last_d;
  logic                  fwd_hit, exists;
  lbbc_box_t             base_box, new_box;
  logic [COORD_W+FW_W-1:0] prod;

  assign accept  = in_i.valid & in_i.ready;
  assign lbl_ok  = {1'b0, in_i.data.label} < (LABEL_W+1)'(NUM_LABELS);
  assign take_px = accept && lbl_ok &&
                   (in_i.data.action == ACT_PIXEL || in_i.data.action == ACT_MERGE);
  assign fin_acc = accept && (in_i.data.action == ACT_FINISH);
  assign out_free = !out_valid_q || out_o.ready;
  assign last_d  = (present_q & ~(NUM_LABELS'(1) << idx_q)) == '0;

  assign in_i.ready  = in_ready;
  assign cfg_i.ready = 1'b1;
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_RUN: begin
        if (fin_acc) state_d = ST_READ;
      end
      ST_READ: begin
        if (present_q == '0) state_d = ST_RUN;
        else if (present_q[idx_q]) state_d = ST_MID;
      end
      ST_MID:  state_d = ST_MUL;
      ST_MUL:  state_d = ST_EMIT;
      ST_EMIT: begin
        if (out_free) state_d = last_d ? ST_RUN : ST_READ;
      end
      default: state_d = ST_RUN;
    endcase
  end

  // state outputs
  always_comb begin
    in_ready = 1'b0;
    scan_rd  = 1'b0;
    emit     = 1'b0;
    idx_d    = idx_q;
    case (state_q)
      ST_RUN: begin
        in_ready = 1'b1;
        idx_d    = '0;
      end
      ST_READ: begin
        scan_rd = present_q[idx_q];
        if (!present_q[idx_q]) idx_d = idx_q + AW'(1);
      end
      ST_EMIT: begin
        emit = out_free;
        if (out_free) idx_d = idx_q + AW'(1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_RUN;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fw_q <= FW_RESET;
    end else if (cfg_i.valid) begin
      fw_q <= cfg_i.data;
    end
  end

  // stage 1: read issued at acceptance
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      fwd_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= take_px;
      fwd_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_px) begin
      s1_lbl_q       <= in_i.data.label[AW-1:0];
      s1_box_q.min_x <= in_i.data.x_low;
      s1_box_q.min_y <= in_i.data.y_low;
      s1_box_q.max_x <= (in_i.data.action == ACT_PIXEL) ? in_i.data.x_low
                                                         : in_i.data.x_high;
      s1_box_q.max_y <= (in_i.data.action == ACT_PIXEL) ? in_i.data.y_low
                                                         : in_i.data.y_high;
    end
    if (s1_valid_q) begin
      fwd_lbl_q <= s1_lbl_q;
      fwd_box_q <= new_box;
    end
  end

  // stage 2: fold and write back
  assign fwd_hit  = fwd_valid_q && (fwd_lbl_q == s1_lbl_q);
  assign base_box = fwd_hit ? fwd_box_q : rd_box_q;
  assign exists   = present_q[s1_lbl_q];

  always_comb begin
    new_box = s1_box_q;
    if (exists) begin
      new_box.min_x = (s1_box_q.min_x < base_box.min_x) ? s1_box_q.min_x : base_box.min_x;
      new_box.min_y = (s1_box_q.min_y < base_box.min_y) ? s1_box_q.min_y : base_box.min_y;
      new_box.max_x = (s1_box_q.max_x > base_box.max_x) ? s1_box_q.max_x : base_box.max_x;
      new_box.max_y = (s1_box_q.max_y > base_box.max_y) ? s1_box_q.max_y : base_box.max_y;
    end
  end

  assign rd_en   = take_px | scan_rd;
  assign rd_addr = (state_q == ST_READ) ? idx_q : in_i.data.label[AW-1:0];

  always_ff @(posedge clk_i) begin
    if (s1_valid_q) box_mem[s1_lbl_q] <= new_box;
    if (rd_en) rd_box_q <= box_mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      present_q <= '0;
    end else if (s1_valid_q) begin
      present_q[s1_lbl_q] <= 1'b1;
    end else if (emit) begin
      present_q[idx_q] <= 1'b0;
    end
  end

  // scan datapath
  assign prod = {{FW_W{1'b0}}, cy_q} * {{COORD_W{1'b0}}, fw_q};

  always_ff @(posedge clk_i) begin
    if (state_q == ST_MID) begin
      cx_q <= mid_point(rd_box_q.min_x, rd_box_q.max_x);
      cy_q <= mid_point(rd_box_q.min_y, rd_box_q.max_y);
    end
    if (state_q == ST_MUL) begin
      center_q <= CENTER_W'(prod + (COORD_W+FW_W)'(cx_q));
    end
    if (emit) begin
      out_q.out_label    <= LABEL_W'(idx_q);
      out_q.center_index <= center_q;
      out_q.last         <= last_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  a_no_stage_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_RUN) |-> !s1_valid_q)
    else $error("stage item alive during scan");

  a_scan_reads_present: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MID) |-> $past(present_q[idx_q]))
    else $error("scan read an absent label");

  a_emit_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |=> !present_q[$past(idx_q)])
    else $error("emitted label still present");

  a_last_ends_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && last_d) |=> (state_q == ST_RUN && present_q == '0))
    else $error("table not empty after last result");

  a_fwd_only_after_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fwd_valid_q |-> $past(s1_valid_q))
    else $error("forward without preceding write");

endmodule

// ===== tb/testbench.sv =====
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import lbbc_pkg::*;

  localparam int LABELS      = 64;
  localparam int IDLE_GAP    = 100;
  localparam int TAIL_CYCLES = 100;
  localparam int LONG_HOLD   = 300;
  localparam int PLAN_LEN    = 21;

  localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

  typedef enum logic [1:0] {
    EXP_MODEL,
    EXP_NONE,
    EXP_ONE
  } row_check_e;

  typedef struct {
    lbbc_in_t            req;
    row_check_e          check;
    logic [LABEL_W-1:0]  t_label;
    logic [CENTER_W-1:0] t_center;
  } step_row_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  lbbc_chan_if #(.T(lbbc_in_t))  req_chan ();
  lbbc_chan_if #(.T(lbbc_out_t)) ctr_chan ();
  lbbc_chan_if #(.T(lbbc_cfg_t)) cfg_chan ();

  label_bounding_box_centers #(
    .NUM_LABELS(LABELS)
  ) i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (req_chan),
    .out_o (ctr_chan),
    .cfg_i (cfg_chan)
  );

  // box table mirror
  bit                 live  [LABELS];
  logic [COORD_W-1:0] bx_lo [LABELS];
  logic [COORD_W-1:0] bx_hi [LABELS];
  logic [COORD_W-1:0] by_lo [LABELS];
  logic [COORD_W-1:0] by_hi [LABELS];
  lbbc_cfg_t          width_q = FW_RESET;

  lbbc_out_t center_q [$];
  lbbc_out_t fresh_q  [$];
  int        mismatches = 0;
  bit        calm = 1'b0;
  bit        hold_off_req = 1'b0;

  step_row_t plan [PLAN_LEN] = '{
    '{'{ACT_FINISH, 6'd0,  12'd0,    12'd0,    12'd0,    12'd0},    EXP_NONE,  6'd0,  24'd0},
    '{'{ACT_PIXEL,  6'd0,  12'd0,    12'd0,    12'd4095, 12'd4095}, EXP_MODEL, 6'd0,  24'd0},
    '{'{ACT_FINISH, 6'd0,  12'd0,    12'd0,    12'd0,    12'd0},    EXP_ONE,   6'd0,  24'd0},
    '{'{ACT_PIXEL,  6'd63, 12'd4095, 12'd4095, 12'd0,    12'd0},    EXP_MODEL, 6'd0,  24'd0},
    '{'{ACT_FINISH, 6'd63, 12'd4095, 12'd4095, 12'd4095, 12'd4095}, EXP_ONE,   6'd63,
      24'd2624895},
    '{'{ACT_MERGE,  6'd5,  12'd0,    12'd0,    12'd4095, 12'd4095}, EXP_MODEL, 6'd0,  24'd0},
    '{'{ACT_FINISH, 6'd0,  12'd0,    12'd0,    12'd0,    12'd0},    EXP_ONE,   6'd5,
      24'd1312127},
    '{'{ACT_MERGE,  6'd7,  12'd4095, 12'd4095, 12'd0,    12'd0},    EXP_MODEL, 6'd0,  24'd0},
    '{'{ACT_FINISH, 6'd0,  12'd0,    12'd0,    12'd0,    12'd0},    EXP_ONE,   6'd7,
      24'd1312768},
    '{'{ACT_UNUSED, 6'd63, 12'd4095, 12'd4095, 12'd4095, 12'd4095}, EXP_MODEL, 6'd0,  24'd0},
    '{'{ACT_FINISH, 6'd0,  12'd0,    12'd0,    12'd0,    12'd0},    EXP_NONE,  6'd0,  24'd0},
    '{'{ACT_PIXEL,  6'd3,  12'd10,   12'd20,   12'd0,    12'd0},    EXP_MODEL, 6'd0,  24'd0},
    '{'{ACT_PIXEL,  6'd3,  12'd30,   12'd4,    12'd4095, 12'd0},    EXP_MODEL, 6'd0,  24'd0},
    '{'{ACT_PIXEL,  6'd1,  12'd100,  12'd200,  12'd0,    12'd4095}, EXP_MODEL, 6'd0,  24'd0},
    '{'{ACT_MERGE,  6'd62, 12'd5,    12'd5,    12'd9,    12'd9},    EXP_MODEL, 6'd0,  24'd0},
    '{'{ACT_MERGE,  6'd3,  12'd8,    12'd2,    12'd12,   12'd40},   EXP_MODEL, 6'd0,  24'd0},
    '{'{ACT_PIXEL,  6'd62, 12'd4095, 12'd0,    12'd0,    12'd0},    EXP_MODEL, 6'd0,  24'd0},
    '{'{ACT_FINISH, 6'd0,  12'd0,    12'd0,    12'd0,    12'd0},    EXP_MODEL, 6'd0,  24'd0},
    '{'{ACT_MERGE,  6'd2,  12'd100,  12'd50,   12'd60,   12'd10},   EXP_MODEL, 6'd0,  24'd0},
    '{'{ACT_PIXEL,  6'd2,  12'd0,    12'd4095, 12'd0,    12'd0},    EXP_MODEL, 6'd0,  24'd0},
    '{'{ACT_FINISH, 6'd0,  12'd0,    12'd0,    12'd0,    12'd0},    EXP_MODEL, 6'd0,  24'd0}
  };

  // lo + (hi - lo) / 2, truncated toward zero
  function automatic logic [COORD_W-1:0] box_mid(logic [COORD_W-1:0] lo,
                                                 logic [COORD_W-1:0] hi);
    int gap;
    gap = int'(hi) - int'(lo);
    return COORD_W'(int'(lo) + gap / 2);
  endfunction

  function automatic logic [COORD_W-1:0] rand_coord();
    if ($urandom_range(0, 7) == 0) begin
      return $urandom_range(0, 1) ? {COORD_W{1'b1}} : {COORD_W{1'b0}};
    end
    return COORD_W'($urandom_range(0, 4095));
  endfunction

  // updates the table mirror, leaves the centers of a finish in fresh_q
  task automatic apply_request(input lbbc_in_t req);
    logic [COORD_W-1:0] x1;
    logic [COORD_W-1:0] y1;
    lbbc_out_t          r;
    longint unsigned    sum;
    fresh_q.delete();
    case (req.action)
      ACT_PIXEL, ACT_MERGE: begin
        x1 = (req.action == ACT_MERGE) ? req.x_high : req.x_low;
        y1 = (req.action == ACT_MERGE) ? req.y_high : req.y_low;
        if (!live[req.label]) begin
          live[req.label]  = 1'b1;
          bx_lo[req.label] = req.x_low;
          by_lo[req.label] = req.y_low;
          bx_hi[req.label] = x1;
          by_hi[req.label] = y1;
        end else begin
          if (req.x_low < bx_lo[req.label]) bx_lo[req.label] = req.x_low;
          if (req.y_low < by_lo[req.label]) by_lo[req.label] = req.y_low;
          if (x1 > bx_hi[req.label]) bx_hi[req.label] = x1;
          if (y1 > by_hi[req.label]) by_hi[req.label] = y1;
        end
      end
      ACT_FINISH: begin
        for (int i = 0; i < LABELS; i++) begin
          if (live[i]) begin
            sum = longint'(box_mid(by_lo[i], by_hi[i])) * longint'(width_q)
                + longint'(box_mid(bx_lo[i], bx_hi[i]));
            r.out_label    = LABEL_W'(i);
            r.center_index = sum[CENTER_W-1:0];
            r.last         = 1'b0;
            fresh_q = {fresh_q, r};
            live[i] = 1'b0;
          end
        end
        if (fresh_q.size() > 0) begin
          r      = fresh_q.pop_back();
          r.last = 1'b1;
          fresh_q = {fresh_q, r};
        end
      end
      default: ;
    endcase
  endtask

  task automatic send_request(input lbbc_in_t req, input bit use_model);
    if (!calm && $urandom_range(0, 5) == 0) begin
      req_chan.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
    req_chan.valid <= 1'b1;
    req_chan.data  <= req;
    do @(posedge clk_i); while (!req_chan.ready);
    apply_request(req);
    if (use_model) begin
      center_q = {center_q, fresh_q};
    end
  endtask

  task automatic drain();
    req_chan.valid <= 1'b0;
    do @(posedge clk_i); while (center_q.size() != 0);
  endtask

  task automatic set_width(input lbbc_cfg_t w);
    drain();
    repeat (IDLE_GAP) @(posedge clk_i);
    cfg_chan.valid <= 1'b1;
    cfg_chan.data  <= w;
    do @(posedge clk_i); while (!cfg_chan.ready);
    cfg_chan.valid <= 1'b0;
    width_q = w;
  endtask

  task automatic run_frames(input int quota, input bit full_sweep, input bit drain_mid);
    lbbc_in_t           req;
    logic [COORD_W-1:0] tmp;
    int                 sent;
    int                 spread;
    int                 n;
    int                 roll;
    bit                 paused;
    sent   = 0;
    paused = 1'b0;
    if (full_sweep) begin
      for (int lab = 0; lab < LABELS; lab++) begin
        req        = '0;
        req.action = ACT_PIXEL;
        req.label  = LABEL_W'(lab);
        req.x_low  = rand_coord();
        req.y_low  = rand_coord();
        req.x_high = rand_coord();
        req.y_high = rand_coord();
        send_request(req, 1'b1);
      end
      req        = '0;
      req.action = ACT_FINISH;
      send_request(req, 1'b1);
    end
    while (sent < quota) begin
      spread = $urandom_range(0, 2);
      n      = $urandom_range(1, 24);
      for (int k = 0; k < n; k++) begin
        case (spread)
          0:       req.label = LABEL_W'($urandom_range(0, 3));
          1:       req.label = LABEL_W'($urandom_range(0, 63));
          default: req.label = LABEL_W'($urandom_range(56, 63));
        endcase
        roll = $urandom_range(0, 99);
        if (roll < 65)      req.action = ACT_PIXEL;
        else if (roll < 92) req.action = ACT_MERGE;
        else if (roll < 96) req.action = ACT_UNUSED;
        else                req.action = ACT_FINISH;
        req.x_low  = rand_coord();
        req.y_low  = rand_coord();
        req.x_high = rand_coord();
        req.y_high = rand_coord();
        if (req.action == ACT_MERGE && $urandom_range(0, 3) != 0) begin
          if (req.x_low > req.x_high) begin
            tmp = req.x_low; req.x_low = req.x_high; req.x_high = tmp;
          end
          if (req.y_low > req.y_high) begin
            tmp = req.y_low; req.y_low = req.y_high; req.y_high = tmp;
          end
        end
        send_request(req, 1'b1);
        if (req.action != ACT_UNUSED) sent++;
      end
      req        = '0;
      req.action = ACT_FINISH;
      req.label  = LABEL_W'($urandom_range(0, 63));
      send_request(req, 1'b1);
      sent++;
      // finish on an already empty table
      if ($urandom_range(0, 9) == 0) send_request(req, 1'b1);
      if (drain_mid && !paused && sent >= quota / 2) begin
        paused = 1'b1;
        drain();
      end
    end
  endtask

  // receiver: random stalls, plus one long hold-off on request
  initial begin : receiver
    int stall_left;
    stall_left = 0;
    ctr_chan.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (stall_left > 0) begin
        stall_left--;
        ctr_chan.ready <= 1'b0;
      end else if (hold_off_req) begin
        hold_off_req = 1'b0;
        stall_left   = LONG_HOLD - 1;
        ctr_chan.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(0, 7);
        ctr_chan.ready <= 1'b0;
      end else begin
        ctr_chan.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    lbbc_out_t got;
    lbbc_out_t want;
    if (rst_ni && ctr_chan.valid && ctr_chan.ready) begin
      got = ctr_chan.data;
      if (center_q.size() == 0) begin
        $error("unexpected result: out_label %0d center_index %0d last %0b",
               got.out_label, got.center_index, got.last);
        mismatches++;
      end else begin
        want = center_q.pop_front();
        if (got.out_label !== want.out_label) begin
          $error("out_label: expected %0d, actual %0d", want.out_label, got.out_label);
          mismatches++;
        end
        if (got.center_index !== want.center_index) begin
          $error("center_index: expected %0d, actual %0d",
                 want.center_index, got.center_index);
          mismatches++;
        end
        if (got.last !== want.last) begin
          $error("last: expected %0b, actual %0b", want.last, got.last);
          mismatches++;
        end
      end
    end
  end

  initial begin : stimulus
    lbbc_out_t typed;
    rst_ni         <= 1'b0;
    req_chan.valid <= 1'b0;
    req_chan.data  <= '0;
    cfg_chan.valid <= 1'b0;
    cfg_chan.data  <= '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[i]) begin
      send_request(plan[i].req, plan[i].check == EXP_MODEL);
      if (plan[i].check == EXP_ONE) begin
        typed.out_label    = plan[i].t_label;
        typed.center_index = plan[i].t_center;
        typed.last         = 1'b1;
        center_q = {center_q, typed};
      end
    end

    set_width(13'd1);
    run_frames(40, 1'b0, 1'b0);
    set_width(13'd4096);
    hold_off_req = 1'b1;
    run_frames(40, 1'b1, 1'b0);
    set_width(13'd8191);
    run_frames(40, 1'b0, 1'b1);
    set_width(13'd0);
    run_frames(40, 1'b0, 1'b0);
    set_width(FW_W'($urandom_range(1, 4096)));
    run_frames(40, 1'b0, 1'b0);
    set_width(FW_RESET);
    calm = 1'b1;
    run_frames(40, 1'b0, 1'b0);

    drain();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
